/* sv/dwc_pkg.sv */
// shared constants and command codes for the deque with cursor
`timescale 1ns / 1ps

package dwc_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths of the stream words
    localparam int CMD_WIDTH   = 3;
    localparam int FIELD_WIDTH = 32;

    typedef logic [CMD_WIDTH-1:0] cmd_t;

    localparam cmd_t CMD_PUSH_LEFT    = 3'd0;
    localparam cmd_t CMD_PUSH_RIGHT   = 3'd1;
    localparam cmd_t CMD_POP_LEFT     = 3'd2;
    localparam cmd_t CMD_POP_RIGHT    = 3'd3;
    localparam cmd_t CMD_CURSOR_LEFT  = 3'd4;
    localparam cmd_t CMD_CURSOR_RIGHT = 3'd5;
    localparam cmd_t CMD_WRITE_CURSOR = 3'd6;
    localparam cmd_t CMD_QUERY        = 3'd7;

endpackage

/* sv/dwc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/dwc_rdport.sv */
// one read view of the ring: ram copy, write bypass and sign extension to a field
`timescale 1ns / 1ps

module dwc_rdport #(
    parameter int DEPTH      = dwc_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dwc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [$clog2(DEPTH)-1:0]            waddr,
    input  logic [DATA_WIDTH-1:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0]            raddr,
    output logic signed [dwc_pkg::FIELD_WIDTH-1:0] rword
);

    import dwc_pkg::*;

    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] byp_reg;
    logic                  hit_reg;
    logic                  hit_next;
    logic [DATA_WIDTH-1:0] held_word;
    logic signed [63:0]    held_ext;

    dwc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // ram reads old data when the same entry is written in that cycle
    assign hit_next = we && (waddr == raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_reg <= wdata;
    end

    assign held_word = hit_reg ? byp_reg : ram_rdata;
    assign held_ext  = 64'(signed'(held_word));
    assign rword     = held_ext[FIELD_WIDTH-1:0];

endmodule

/* sv/deque_with_cursor_unit.sv */
// top level of the bounded deque with cursor over a ring of words
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed words kept in a ring, with a
// cursor on one held entry. One command word is taken per clock cycle and its
// result word appears in the cycle after it is taken; the input is ready
// whenever the result register is empty or being drained. The index update
// for a command is a few increments and compares; the ring itself is held in
// three copies of a small ram, all written alike and read at the left end,
// right end and cursor index of the next state, so the three reported entries
// come out of the ram registers in the same cycle as the result. Stored words
// are DATA_WIDTH bits; pushed words are truncated to that width and reported
// sign extended. No clearing pass: entries are only read once pushed.

module deque_with_cursor_unit #(
    parameter int DEPTH      = dwc_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dwc_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,

    // command words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd [2:0], value [34:3], zero fill above
    input  logic [((dwc_pkg::CMD_WIDTH + dwc_pkg::FIELD_WIDTH + 7) / 8) * 8 - 1:0]
                        s_axis_tdata,

    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // popped, ok, count, left_value, right_value, cursor_value, zero fill above
    output logic [((4 * dwc_pkg::FIELD_WIDTH + 1 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                        m_axis_tdata
);

    import dwc_pkg::*;

    localparam int AW       = $clog2(DEPTH);
    localparam int FW       = $clog2(DEPTH + 1);
    localparam int SW       = AW + 1;
    localparam int OUT_BITS = 4 * FIELD_WIDTH + 1 + FW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // ring index helpers, DEPTH need not be a power of two
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        idx_inc = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        idx_dec = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    // input word fields
    cmd_t                    in_cmd;
    logic signed [FIELD_WIDTH-1:0] in_value;
    logic signed [63:0]      value_ext;
    logic [DATA_WIDTH-1:0]   in_word;

    assign in_cmd    = s_axis_tdata[CMD_WIDTH-1:0];
    assign in_value  = s_axis_tdata[CMD_WIDTH +: FIELD_WIDTH];
    assign value_ext = 64'(in_value);
    assign in_word   = value_ext[DATA_WIDTH-1:0];

    // ring state: right index always equals left + fill - 1 around the ring
    logic [AW-1:0] left_reg,  left_next;
    logic [AW-1:0] right_reg, right_next;
    logic [AW-1:0] cur_reg,   cur_next;
    logic [AW-1:0] off_reg,   off_next;
    logic [FW-1:0] fill_reg,  fill_next;

    // result register
    logic                    res_valid_reg, res_valid_next;
    logic                    res_ok_reg,    ok_next;
    logic [FIELD_WIDTH-1:0]  res_popped_reg, popped_next;

    // ram write
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;

    // entries of the current state, as field words
    logic signed [FIELD_WIDTH-1:0] left_word, right_word, cur_word;

    logic          accept;
    logic          empty;
    logic          full;
    logic [FW-1:0] off_plus;
    logic [FW-1:0] fill_minus;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !res_valid_reg || m_axis_tready;
    assign empty         = (fill_reg == '0);
    assign full          = (fill_reg == FW'(DEPTH));
    assign off_plus      = FW'(off_reg) + FW'(1);
    assign fill_minus    = fill_reg - FW'(1);

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        cur_next    = cur_reg;
        off_next    = off_reg;
        fill_next   = fill_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        ok_next     = 1'b0;
        popped_next = '0;

        if (accept)
        begin
            case (in_cmd)
                CMD_PUSH_LEFT:
                begin
                    if (!full)
                    begin
                        left_next = idx_dec(left_reg);
                        wr_en     = 1'b1;
                        wr_addr   = idx_dec(left_reg);
                        fill_next = fill_reg + FW'(1);
                        ok_next   = 1'b1;
                        // cursor keeps its entry, one further from the left end
                        if (empty)
                        begin
                            cur_next = idx_dec(left_reg);
                            off_next = '0;
                        end
                        else
                        begin
                            off_next = off_reg + AW'(1);
                        end
                    end
                end
                CMD_PUSH_RIGHT:
                begin
                    if (!full)
                    begin
                        right_next = idx_inc(right_reg);
                        wr_en      = 1'b1;
                        wr_addr    = idx_inc(right_reg);
                        fill_next  = fill_reg + FW'(1);
                        ok_next    = 1'b1;
                        if (empty)
                        begin
                            cur_next = idx_inc(right_reg);
                            off_next = '0;
                        end
                    end
                end
                CMD_POP_LEFT:
                begin
                    if (empty)
                    begin
                        popped_next = '1;
                    end
                    else
                    begin
                        popped_next = left_word;
                        left_next   = idx_inc(left_reg);
                        fill_next   = fill_minus;
                        ok_next     = 1'b1;
                        // cursor on the left end moves inward
                        if (off_reg != '0)
                        begin
                            off_next = off_reg - AW'(1);
                        end
                        else
                        begin
                            cur_next = idx_inc(left_reg);
                        end
                    end
                end
                CMD_POP_RIGHT:
                begin
                    if (empty)
                    begin
                        popped_next = '1;
                    end
                    else
                    begin
                        popped_next = right_word;
                        right_next  = idx_dec(right_reg);
                        fill_next   = fill_minus;
                        ok_next     = 1'b1;
                        if ((FW'(off_reg) == fill_minus) && (off_reg != '0))
                        begin
                            off_next = off_reg - AW'(1);
                            cur_next = idx_dec(cur_reg);
                        end
                    end
                end
                CMD_CURSOR_LEFT:
                begin
                    if (!empty && (off_reg != '0))
                    begin
                        off_next = off_reg - AW'(1);
                        cur_next = idx_dec(cur_reg);
                        ok_next  = 1'b1;
                    end
                end
                CMD_CURSOR_RIGHT:
                begin
                    if (!empty && (off_plus < fill_reg))
                    begin
                        off_next = off_reg + AW'(1);
                        cur_next = idx_inc(cur_reg);
                        ok_next  = 1'b1;
                    end
                end
                CMD_WRITE_CURSOR:
                begin
                    if (!empty)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = cur_reg;
                        ok_next = 1'b1;
                    end
                end
                CMD_QUERY:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= AW'(DEPTH - 1);
            cur_reg       <= '0;
            off_reg       <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            cur_reg       <= cur_next;
            off_reg       <= off_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_ok_reg     <= ok_next;
            res_popped_reg <= popped_next;
        end
    end

    // three ring copies, read at the next state's indices so the registered words
    // line up with the updated state registers
    dwc_rdport #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_left_port (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_word),
        .raddr (left_next),
        .rword (left_word)
    );

    dwc_rdport #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_right_port (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_word),
        .raddr (right_next),
        .rword (right_word)
    );

    dwc_rdport #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cur_port (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_word),
        .raddr (cur_next),
        .rword (cur_word)
    );

    // result word; entry fields read zero on an empty deque
    logic [FIELD_WIDTH-1:0] left_out, right_out, cur_out;

    assign left_out  = empty ? '0 : left_word;
    assign right_out = empty ? '0 : right_word;
    assign cur_out   = empty ? '0 : cur_word;

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = OUT_W'({cur_out, right_out, left_out, fill_reg,
                                   res_ok_reg, res_popped_reg});

    // expected right end, for checking the ring bookkeeping
    logic [SW-1:0] right_sum;
    logic [AW-1:0] right_expect;

    assign right_sum    = SW'(left_reg) + SW'(fill_reg) - SW'(1);
    assign right_expect = empty ? idx_dec(left_reg) :
                          (right_sum >= SW'(DEPTH)) ? AW'(right_sum - SW'(DEPTH)) :
                                                      AW'(right_sum);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && off_reg == '0) || (!empty && FW'(off_reg) < fill_reg))
        else $error("cursor offset outside held entries");

    a_right_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        right_reg == right_expect)
        else $error("right index out of step with left index and fill");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && (in_cmd == CMD_POP_LEFT || in_cmd == CMD_POP_RIGHT))
        |=> (m_axis_tvalid && res_popped_reg == '1 && !res_ok_reg))
        else $error("pop on empty deque did not report failure");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full && (in_cmd == CMD_PUSH_LEFT || in_cmd == CMD_PUSH_RIGHT))
        |=> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("accepted push did not add one entry");

endmodule

/* tb/deque_with_cursor_unit_tb.sv */
// self-checking testbench for the deque with cursor unit
`timescale 1ns / 1ps

// directed table of commands first, then random bursts that fill, drain and
// walk the deque; every result word is checked against a software deque kept
// alongside the block, but the obvious rows use typed-in expectations instead
module deque_with_cursor_unit_tb;
    import dwc_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int S_W          = ((CMD_WIDTH + FIELD_WIDTH + 7) / 8) * 8;
    localparam int M_W          = ((4 * FIELD_WIDTH + 1 + CNT_W + 7) / 8) * 8;
    localparam int OFS_OK       = FIELD_WIDTH;
    localparam int OFS_COUNT    = OFS_OK + 1;
    localparam int OFS_LEFT     = OFS_COUNT + CNT_W;
    localparam int OFS_RIGHT    = OFS_LEFT + FIELD_WIDTH;
    localparam int OFS_CURSOR   = OFS_RIGHT + FIELD_WIDTH;
    localparam int RANDOM_WORDS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_SHOWN    = 10;
    localparam int SETTLE       = 8;

    // one result word, unpacked
    typedef struct packed {
        logic [31:0]      popped;
        logic             ok;
        logic [CNT_W-1:0] count;
        logic [31:0]      left_value;
        logic [31:0]      right_value;
        logic [31:0]      cursor_value;
    } deque_result_t;

    // one directed command; typed rows carry their own expected result
    typedef struct packed {
        cmd_t          cmd;
        logic [31:0]   value;
        logic          typed;
        deque_result_t typed_res;
    } cmd_row_t;

    logic           clk;
    logic           rst_n         = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [S_W-1:0] s_axis_tdata  = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [M_W-1:0] m_axis_tdata;

    // software copy of the ring
    logic [31:0] dq_store [DEPTH];
    int          dq_head = 0;
    int          dq_fill = 0;
    int          dq_cur  = 0;

    deque_result_t expected_q [$];
    cmd_row_t      cmd_table [$];
    deque_result_t got_res;
    deque_result_t want_res;

    int src_idle_pct  = 13;
    int snk_idle_pct  = 68;
    int cycles        = 0;
    int mismatches    = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int full_refusals = 0;
    int empty_pops    = 0;
    int edge_refusals = 0;
    int peak_fill     = 0;

    deque_with_cursor_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int ring_slot(int offset);
        return (dq_head + offset) % DEPTH;
    endfunction

    // apply one command to the software deque and return its result word
    function automatic deque_result_t deque_apply(cmd_t c, logic [31:0] v);
        deque_result_t r;
        r = '0;
        case (c)
            CMD_PUSH_LEFT, CMD_PUSH_RIGHT:
                if (dq_fill < DEPTH)
                begin
                    if (c == CMD_PUSH_LEFT)
                    begin
                        dq_head = (dq_head + DEPTH - 1) % DEPTH;
                        dq_store[dq_head] = v;
                        // cursor stays on its entry, whose offset grows by one
                        dq_cur = (dq_fill == 0) ? 0 : dq_cur + 1;
                    end
                    else
                    begin
                        dq_store[ring_slot(dq_fill)] = v;
                        if (dq_fill == 0)
                            dq_cur = 0;
                    end
                    dq_fill++;
                    r.ok = 1'b1;
                end
                else
                    full_refusals++;
            CMD_POP_LEFT, CMD_POP_RIGHT:
                if (dq_fill == 0)
                begin
                    r.popped = '1;
                    empty_pops++;
                end
                else
                begin
                    if (c == CMD_POP_LEFT)
                    begin
                        r.popped = dq_store[ring_slot(0)];
                        if (dq_cur > 0)
                            dq_cur--;
                        dq_head = ring_slot(1);
                    end
                    else
                    begin
                        r.popped = dq_store[ring_slot(dq_fill - 1)];
                        // cursor on the popped entry moves inward
                        if (dq_cur == dq_fill - 1 && dq_cur > 0)
                            dq_cur--;
                    end
                    dq_fill--;
                    r.ok = 1'b1;
                end
            CMD_CURSOR_LEFT:
                if (dq_fill > 0 && dq_cur > 0)
                begin
                    dq_cur--;
                    r.ok = 1'b1;
                end
                else
                    edge_refusals++;
            CMD_CURSOR_RIGHT:
                if (dq_fill > 0 && dq_cur + 1 < dq_fill)
                begin
                    dq_cur++;
                    r.ok = 1'b1;
                end
                else
                    edge_refusals++;
            CMD_WRITE_CURSOR:
                if (dq_fill > 0)
                begin
                    dq_store[ring_slot(dq_cur)] = v;
                    r.ok = 1'b1;
                end
            default:
                r.ok = 1'b1;
        endcase
        if (dq_fill == 0)
            dq_cur = 0;
        if (dq_fill > peak_fill)
            peak_fill = dq_fill;
        r.count = CNT_W'(dq_fill);
        if (dq_fill > 0)
        begin
            r.left_value   = dq_store[ring_slot(0)];
            r.right_value  = dq_store[ring_slot(dq_fill - 1)];
            r.cursor_value = dq_store[ring_slot(dq_cur)];
        end
        return r;
    endfunction

    function automatic deque_result_t mk_res(logic [31:0] popped, logic ok, int count,
                                             logic [31:0] lv, logic [31:0] rv,
                                             logic [31:0] cv);
        deque_result_t r;
        r.popped       = popped;
        r.ok           = ok;
        r.count        = CNT_W'(count);
        r.left_value   = lv;
        r.right_value  = rv;
        r.cursor_value = cv;
        return r;
    endfunction

    task automatic add_row(cmd_t c, logic [31:0] v, logic typed, deque_result_t res);
        cmd_row_t row;
        row.cmd       = c;
        row.value     = v;
        row.typed     = typed;
        row.typed_res = res;
        cmd_table.push_back(row);
    endtask

    // word values lean toward the extremes now and then
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mode 0 fills, mode 1 drains, mode 2 is uniform over all commands
    function automatic cmd_t pick_cmd(int mode);
        int roll;
        roll = $urandom_range(99);
        if (mode == 0 && roll < 70)
            return ($urandom_range(1) == 0) ? CMD_PUSH_LEFT : CMD_PUSH_RIGHT;
        if (mode == 1 && roll < 60)
            return ($urandom_range(1) == 0) ? CMD_POP_LEFT : CMD_POP_RIGHT;
        return cmd_t'($urandom_range(7));
    endfunction

    task automatic log_mismatch(string what, deque_result_t want, deque_result_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
        begin
            $display("[%0t] %s: want popped %0d ok %0d count %0d l/r/c %0d %0d %0d",
                     $realtime, what,
                     $signed(want.popped), want.ok, want.count, $signed(want.left_value),
                     $signed(want.right_value), $signed(want.cursor_value));
            $display("    got popped %0d ok %0d count %0d l/r/c %0d %0d %0d",
                     $signed(got.popped), got.ok, got.count, $signed(got.left_value),
                     $signed(got.right_value), $signed(got.cursor_value));
        end
    endtask

    // offer one command word with random idle cycles ahead of it
    task automatic send_word(cmd_t c, logic [31:0] v, logic typed, deque_result_t typed_res);
        deque_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_W - CMD_WIDTH - FIELD_WIDTH){1'b0}}, v, c};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // state always advances, typed rows just supply their own expectation
        predicted = deque_apply(c, v);
        expected_q.push_back(typed ? typed_res : predicted);
        words_sent++;
    endtask

    // result side: check every accepted word, then decide the next stall
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_res.popped       = m_axis_tdata[0 +: FIELD_WIDTH];
                got_res.ok           = m_axis_tdata[OFS_OK];
                got_res.count        = m_axis_tdata[OFS_COUNT +: CNT_W];
                got_res.left_value   = m_axis_tdata[OFS_LEFT +: FIELD_WIDTH];
                got_res.right_value  = m_axis_tdata[OFS_RIGHT +: FIELD_WIDTH];
                got_res.cursor_value = m_axis_tdata[OFS_CURSOR +: FIELD_WIDTH];
                if (expected_q.size() == 0)
                    log_mismatch("result word with no command outstanding", '0, got_res);
                else
                begin
                    want_res = expected_q.pop_front();
                    if (got_res !== want_res)
                        log_mismatch("result word mismatch", want_res, got_res);
                end
                results_seen++;
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped by watchdog after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int n_random;
        int mode;
        int burst;

        // special cases on the empty deque, then the first two pushes
        add_row(CMD_QUERY,        32'h0,         1'b1, mk_res(32'h0, 1'b1, 0, 0, 0, 0));
        add_row(CMD_POP_LEFT,     32'h0,         1'b1, mk_res(32'hffff_ffff, 1'b0, 0, 0, 0, 0));
        add_row(CMD_POP_RIGHT,    32'h1234,      1'b1, mk_res(32'hffff_ffff, 1'b0, 0, 0, 0, 0));
        add_row(CMD_CURSOR_LEFT,  32'h0,         1'b1, mk_res(32'h0, 1'b0, 0, 0, 0, 0));
        add_row(CMD_CURSOR_RIGHT, 32'h0,         1'b1, mk_res(32'h0, 1'b0, 0, 0, 0, 0));
        add_row(CMD_WRITE_CURSOR, 32'h5,         1'b1, mk_res(32'h0, 1'b0, 0, 0, 0, 0));
        add_row(CMD_PUSH_LEFT,    32'h7fff_ffff, 1'b1,
                mk_res(32'h0, 1'b1, 1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        add_row(CMD_PUSH_RIGHT,   32'h8000_0000, 1'b1,
                mk_res(32'h0, 1'b1, 2, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        // cursor at both edges, writes, pops around the cursor entry
        add_row(CMD_CURSOR_LEFT,  32'h0,         1'b0, '0);
        add_row(CMD_CURSOR_RIGHT, 32'h0,         1'b0, '0);
        add_row(CMD_CURSOR_RIGHT, 32'h0,         1'b0, '0);
        add_row(CMD_WRITE_CURSOR, 32'hffff_ffff, 1'b0, '0);
        add_row(CMD_PUSH_LEFT,    32'h0,         1'b0, '0);
        add_row(CMD_PUSH_RIGHT,   32'h1,         1'b0, '0);
        add_row(CMD_POP_RIGHT,    32'h0,         1'b0, '0);
        add_row(CMD_POP_RIGHT,    32'h0,         1'b0, '0);
        add_row(CMD_POP_LEFT,     32'h0,         1'b0, '0);
        add_row(CMD_WRITE_CURSOR, 32'h5555_5555, 1'b0, '0);
        add_row(CMD_POP_LEFT,     32'h0,         1'b0, '0);
        add_row(CMD_QUERY,        32'hffff_ffff, 1'b0, '0);
        // push into empty from the right, then left push keeps the cursor
        add_row(CMD_PUSH_RIGHT,   32'haaaa_aaaa, 1'b0, '0);
        add_row(CMD_PUSH_LEFT,    32'h1,         1'b0, '0);
        add_row(CMD_QUERY,        32'h0,         1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (cmd_table[i])
            send_word(cmd_table[i].cmd, cmd_table[i].value, cmd_table[i].typed,
                      cmd_table[i].typed_res);

        // random bursts; idle pattern swaps after a third, stops after two
        n_random = 0;
        while (n_random < RANDOM_WORDS)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(32, 8);
            for (int k = 0; k < burst && n_random < RANDOM_WORDS; k++)
            begin
                if (n_random == RANDOM_WORDS / 3)
                begin
                    src_idle_pct = 68;
                    snk_idle_pct = 13;
                end
                else if (n_random == 2 * RANDOM_WORDS / 3)
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                send_word(pick_cmd(mode), pick_value(), 1'b0, '0);
                n_random++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (expected_q.size() != 0)
            mismatches++;

        $display("%0d command words (%0d from the table), %0d result words checked, %0d bad",
                 words_sent, cmd_table.size(), results_seen, mismatches);
        $display("peak fill %0d of %0d, %0d pushes on full, %0d pops on empty,",
                 peak_fill, DEPTH, full_refusals, empty_pops);
        $display("%0d cursor moves refused", edge_refusals);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
sv/dwc_pkg.sv
sv/dwc_ram.sv
sv/dwc_rdport.sv
sv/deque_with_cursor_unit.sv
tb/deque_with_cursor_unit_tb.sv
